[src/tksd_pkg.sv]
// ----------------------------------------------------------------------------
// tksd_pkg
// Types and constants shared by the timed key sequence detector.
// ----------------------------------------------------------------------------
package tksd_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] CFG_CODES_LOW  = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_CODES_HIGH = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_CMD_LENGTH = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_TIME_WIN   = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_BTN_COUNT  = 3'd4;

  // Event types
  localparam logic [7:0] EV_BUTTON = 8'd1;
  localparam logic [7:0] EV_AXIS   = 8'd2;

  localparam int unsigned CodeW    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LenW     = 5;
  localparam int unsigned MaxCmd   = 16;
  localparam int unsigned EntryW   = CodeW + TimeW;

  // Reset values of the configuration registers
  localparam logic [63:0]      RST_CODES_LOW  = 64'h0908_0908_0B0B_0A0A;
  localparam logic [63:0]      RST_CODES_HIGH = 64'h0000_0000_0000_0302;
  localparam logic [LenW-1:0]  RST_CMD_LENGTH = 5'd10;
  localparam logic [TimeW-1:0] RST_TIME_WIN   = 32'd5000;
  localparam logic [7:0]       RST_BTN_COUNT  = 8'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } tksd_state_t;

  // Pick command code k out of the two packed command words
  function automatic logic [CodeW-1:0] command_code(input logic [63:0] lo,
                                                    input logic [63:0] hi,
                                                    input logic [3:0]  k);
    logic [63:0] word;
    word = k[3] ? hi : lo;
    return word[{k[2:0], 3'b000} +: CodeW];
  endfunction

endpackage

[src/tksd_ram.sv]
// ----------------------------------------------------------------------------
// tksd_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module tksd_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/timed_key_sequence_detector.sv]
// ----------------------------------------------------------------------------
// timed_key_sequence_detector
// Maps joystick events to key codes and flags a timed command sequence.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one joystick event per word; the event type travels in in_tuser,
//           number, value and time in in_tdata.
//   out_* : one word per key press (matched, key_code); events that are not
//           key presses are taken and give no word.
//   cfg_* : command codes, command length, window and button count; write
//           only while the block is idle.
// Each key press is written into a ring history RAM and the last L entries
// (L the configured command length) are then read back one a cycle through
// a single registered read port and checked against the command by one
// comparator. A key press passes from idle through the scan to a finish step
// that loads the result word; an invalid or not yet reachable length goes
// straight to the finish step. Dropped events are taken in idle and leave
// it idle. in_tready is high only while idle. The result sits in an output
// register; while the receiver stalls the next item may still be taken and
// processed, and the block then holds in its last step until the register is
// free. Reset clears the fill count and write position and loads the default
// configuration; the RAM needs no clearing since only stored entries are read.
// ----------------------------------------------------------------------------
module timed_key_sequence_detector
  import tksd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // in_tuser: event_type[7:0]
  input  logic [7:0]          in_tuser,
  // in_tdata: event_number[7:0], event_value[23:8], event_time[55:24]
  input  logic [55:0]         in_tdata,
  // out_tdata: matched[0], key_code[8:1], zero[15:9]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [63:0]         cfg_wdata
);

  localparam int unsigned AW     = $clog2(HISTORY_DEPTH);
  localparam int unsigned PW     = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CmpW   = (PW > LenW) ? PW + 1 : LenW + 1;
  localparam int unsigned IdxW   = (AW > LenW) ? AW + 1 : LenW + 1;
  localparam logic [AW-1:0] LastIdx = AW'(HISTORY_DEPTH - 1);
  localparam logic [PW-1:0] FullCnt = PW'(HISTORY_DEPTH);

  // Configuration registers
  logic [63:0]      codes_lo_r, codes_hi_r;
  logic [LenW-1:0]  cmd_len_r;
  logic [TimeW-1:0] time_win_r;
  logic [7:0]       btn_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_lo_r <= RST_CODES_LOW;
      codes_hi_r <= RST_CODES_HIGH;
      cmd_len_r  <= RST_CMD_LENGTH;
      time_win_r <= RST_TIME_WIN;
      btn_cnt_r  <= RST_BTN_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CODES_LOW:  codes_lo_r <= cfg_wdata;
        CFG_CODES_HIGH: codes_hi_r <= cfg_wdata;
        CFG_CMD_LENGTH: cmd_len_r  <= cfg_wdata[LenW-1:0];
        CFG_TIME_WIN:   time_win_r <= cfg_wdata[TimeW-1:0];
        CFG_BTN_COUNT:  btn_cnt_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic [7:0]       ev_type, ev_num;
  logic [15:0]      ev_val;
  logic [TimeW-1:0] ev_time;
  assign ev_type = in_tuser;
  assign ev_num  = in_tdata[7:0];
  assign ev_val  = in_tdata[23:8];
  assign ev_time = in_tdata[55:24];

  // Key mapping
  logic             val_nz, val_pos, is_btn, is_axis, is_key;
  logic [CodeW-1:0] key_code;
  assign val_nz  = (ev_val != 16'd0);
  assign val_pos = val_nz && !ev_val[15];
  assign is_btn  = (ev_type == EV_BUTTON) && val_pos;
  assign is_axis = (ev_type == EV_AXIS) && val_nz;
  assign is_key  = is_btn || is_axis;
  assign key_code = is_btn ? ev_num
                  : btn_cnt_r + {ev_num[6:0], 1'b0} + {7'd0, val_pos};

  // Sequencer state
  tksd_state_t      state_r, state_nxt;
  logic [AW-1:0]    wpos_r, wpos_nxt;
  logic [PW-1:0]    presses_r, presses_nxt;
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [LenW-1:0]  cnt_r, cnt_nxt;
  logic             ok_r, ok_nxt;
  logic [CodeW-1:0] code_r, code_nxt;
  logic [TimeW-1:0] t_last_r, t_last_nxt;
  logic [TimeW-1:0] t_first_r, t_first_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_match_r, out_match_nxt;
  logic [CodeW-1:0] out_code_r, out_code_nxt;

  logic              accept, ram_we;
  logic [EntryW-1:0] ram_rdata;
  logic [PW-1:0]     presses_inc;
  logic              len_ok;
  logic [LenW-1:0]   len_m1;
  logic [IdxW-1:0]   first_wide;
  logic [AW-1:0]     first_idx;
  logic [CodeW-1:0]  exp_code;
  logic [LenW-1:0]   cnt_m1;
  logic              out_free;

  assign accept   = in_tvalid && in_tready;
  assign ram_we   = accept && is_key;
  assign out_free = !out_valid_r || out_tready;

  assign presses_inc = (presses_r == FullCnt) ? presses_r : presses_r + PW'(1);

  // Length must be 1..16, fit the history and be covered by stored presses
  assign len_ok = (cmd_len_r != '0)
               && (CmpW'(cmd_len_r) <= CmpW'(MaxCmd))
               && (CmpW'(cmd_len_r) <= CmpW'(HISTORY_DEPTH))
               && (CmpW'(cmd_len_r) <= CmpW'(presses_inc));

  // Oldest entry of the sequence, back from the write position with wrap
  assign len_m1 = cmd_len_r - LenW'(1);
  always_comb begin
    if (IdxW'(wpos_r) >= IdxW'(len_m1)) begin
      first_wide = IdxW'(wpos_r) - IdxW'(len_m1);
    end else begin
      first_wide = IdxW'(wpos_r) + IdxW'(HISTORY_DEPTH) - IdxW'(len_m1);
    end
  end
  assign first_idx = first_wide[AW-1:0];

  assign cnt_m1   = cnt_r - LenW'(1);
  assign exp_code = command_code(codes_lo_r, codes_hi_r, cnt_m1[3:0]);

  tksd_ram #(
    .WIDTH (EntryW),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpos_r),
    .wdata ({ev_time, key_code}),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wpos_r      <= '0;
      presses_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wpos_r      <= wpos_nxt;
      presses_r   <= presses_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    cnt_r       <= cnt_nxt;
    ok_r        <= ok_nxt;
    code_r      <= code_nxt;
    t_last_r    <= t_last_nxt;
    t_first_r   <= t_first_nxt;
    out_match_r <= out_match_nxt;
    out_code_r  <= out_code_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    wpos_nxt      = wpos_r;
    presses_nxt   = presses_r;
    rd_addr_nxt   = rd_addr_r;
    cnt_nxt       = cnt_r;
    ok_nxt        = ok_r;
    code_nxt      = code_r;
    t_last_nxt    = t_last_r;
    t_first_nxt   = t_first_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_match_nxt = out_match_r;
    out_code_nxt  = out_code_r;
    in_tready     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && is_key) begin
          wpos_nxt    = (wpos_r == LastIdx) ? '0 : wpos_r + AW'(1);
          presses_nxt = presses_inc;
          rd_addr_nxt = first_idx;
          cnt_nxt     = '0;
          ok_nxt      = len_ok;
          code_nxt    = key_code;
          t_last_nxt  = ev_time;
          state_nxt   = len_ok ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        // issue entry cnt, check the one read last cycle
        rd_addr_nxt = (rd_addr_r == LastIdx) ? '0 : rd_addr_r + AW'(1);
        cnt_nxt     = cnt_r + LenW'(1);
        if (cnt_r != '0) begin
          if (ram_rdata[CodeW-1:0] != exp_code) begin
            ok_nxt = 1'b0;
          end
          if (cnt_r == LenW'(1)) begin
            t_first_nxt = ram_rdata[EntryW-1:CodeW];
          end
        end
        if (cnt_r == cmd_len_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = ok_r && ((t_last_r - t_first_r) <= time_win_r);
          out_code_nxt  = code_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_code_r, out_match_r};

  // Fill count never passes the history depth
  a_presses_sat: assert property (@(posedge clk) disable iff (!rst_n)
    presses_r <= FullCnt)
    else $error("fill count above history depth");

  // A key press always starts the scan or goes straight to the result
  a_key_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_key |=> state_r == ST_SCAN || state_r == ST_FINISH)
    else $error("key press did not start processing");

  // Scan counter stays within the command length
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> cnt_r <= cmd_len_r)
    else $error("scan ran past command length");

  // A match is only reported once enough presses are stored
  a_match_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_match_r |-> CmpW'(presses_r) >= CmpW'(cmd_len_r))
    else $error("match reported with too few presses");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timed key sequence detector.
// A queue of joystick event words feeds a driver on the input stream while a
// monitor predicts each key press (key code, fill count, command compare and
// time span with 32-bit wrap) and checks every result word in order. A short
// directed part covers the fill count, ignored events, the exact window edge
// and field extremes; random phases then sweep command lengths, windows and
// button counts under three patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import tksd_pkg::*;

  localparam int HalfPeriod    = 4;
  localparam int Depth         = 16;
  localparam int SettleCycles  = 40;
  localparam int DrainLimit    = 50000;
  localparam int ReportLimit   = 10;
  localparam int TimeoutCycles = 2000000;

  typedef struct packed {
    logic       matched;
    logic [7:0] key_code;
  } press_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  // in_tuser: event_type[7:0]
  logic [7:0]          in_tuser   = '0;
  // in_tdata: event_number[7:0], event_value[23:8], event_time[55:24]
  logic [55:0]         in_tdata   = '0;
  // out_tdata: matched[0], key_code[8:1], zero[15:9]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [15:0]         out_tdata;
  logic                cfg_we     = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr   = CFG_CODES_LOW;
  logic [63:0]         cfg_wdata  = '0;

  timed_key_sequence_detector #(.HISTORY_DEPTH(Depth)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the configuration registers
  logic [63:0]      cmd_lo  = RST_CODES_LOW;
  logic [63:0]      cmd_hi  = RST_CODES_HIGH;
  logic [LenW-1:0]  cmd_len = RST_CMD_LENGTH;
  logic [TimeW-1:0] win     = RST_TIME_WIN;
  logic [7:0]       btn_cnt = RST_BTN_COUNT;

  // Shadow of the press history
  logic [7:0]  hist_code [Depth] = '{default: '0};
  logic [31:0] hist_time [Depth] = '{default: '0};
  logic [3:0]  hist_wr   = '0;
  int          hist_fill = 0;

  logic [63:0] event_backlog [$];
  press_t      press_expect  [$];

  logic        in_taken       = 1'b0;
  logic [31:0] clock_ms       = '0;
  int          send_idle      = 31;
  int          recv_idle      = 67;
  int          queued_count   = 0;
  int          taken_count    = 0;
  int          presses_queued = 0;
  int          press_count    = 0;
  int          hit_count      = 0;
  int          mismatch_count = 0;
  int          setting_count  = 0;

  initial begin
    forever #HalfPeriod clk = ~clk;
  end

  function automatic logic [7:0] cmd_byte(input int k);
    return (k < 8) ? cmd_lo[8*k +: 8] : cmd_hi[8*(k-8) +: 8];
  endfunction

  // Map one event word to a key press, store it and score the command
  function automatic bit decode_and_match(input logic [63:0] word, output press_t res);
    logic [7:0]         ev_kind;
    logic [7:0]         ev_num;
    logic signed [15:0] ev_val;
    logic [31:0]        ev_time;
    logic [7:0]         code;
    logic [3:0]         first_idx;
    int                 len;
    bit                 hit;
    ev_kind = word[7:0];
    ev_num  = word[15:8];
    ev_val  = word[31:16];
    ev_time = word[63:32];
    res     = '0;
    if (ev_kind == EV_BUTTON && ev_val > 0) begin
      code = ev_num;
    end else if (ev_kind == EV_AXIS && ev_val != 0) begin
      code = btn_cnt + {ev_num[6:0], 1'b0} + ((ev_val > 0) ? 8'd1 : 8'd0);
    end else begin
      return 1'b0;
    end
    hist_code[hist_wr] = code;
    hist_time[hist_wr] = ev_time;
    if (hist_fill < Depth) hist_fill++;
    len = int'(cmd_len);
    hit = (len >= 1) && (len <= int'(MaxCmd)) && (len <= Depth) && (hist_fill >= len);
    if (hit) begin
      first_idx = hist_wr - 4'(len - 1);
      for (int k = 0; k < len; k++) begin
        if (hist_code[4'(first_idx + k)] != cmd_byte(k)) hit = 1'b0;
      end
      if (hist_time[hist_wr] - hist_time[first_idx] > win) hit = 1'b0;
    end
    hist_wr      = hist_wr + 4'd1;
    res.matched  = hit;
    res.key_code = code;
    return 1'b1;
  endfunction

  task automatic note_failure(input string what, input press_t want, input logic [15:0] seen);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t %s: expected matched=%0d key_code=%0d, seen matched=%0d key_code=%0d pad=%0h",
               $time, what, want.matched, want.key_code, seen[0], seen[8:1], seen[15:9]);
    end
  endtask

  // Driver: advance only once the current word has been taken
  always @(negedge clk) begin : driver
    logic [63:0] pending;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (event_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
        pending    = event_backlog.pop_front();
        in_tuser  <= pending[7:0];
        in_tdata  <= pending[63:8];
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // Monitor: check result words, then predict from the taken event word
  always @(posedge clk) begin : monitor
    press_t want;
    press_t fresh;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (press_expect.size() == 0) begin
        note_failure("result word with nothing expected", '0, out_tdata);
      end else begin
        want = press_expect.pop_front();
        press_count++;
        if (want.matched) hit_count++;
        if (out_tdata[0] != want.matched || out_tdata[8:1] != want.key_code ||
            out_tdata[15:9] != '0)
          note_failure("result word mismatch", want, out_tdata);
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      taken_count++;
      if (decode_and_match({in_tdata, in_tuser}, fresh)) press_expect.push_back(fresh);
    end
  end

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    case (addr)
      CFG_CODES_LOW:  cmd_lo  = value;
      CFG_CODES_HIGH: cmd_hi  = value;
      CFG_CMD_LENGTH: cmd_len = value[LenW-1:0];
      CFG_TIME_WIN:   win     = value[TimeW-1:0];
      CFG_BTN_COUNT:  btn_cnt = value[7:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  task automatic queue_word(input logic [7:0] kind, input logic [7:0] number,
                            input logic [15:0] value, input logic [31:0] stamp);
    event_backlog.push_back({stamp, value, number, kind});
    queued_count++;
  endtask

  // Encode a key code as a button press or as the matching axis move
  task automatic queue_press(input logic [7:0] code, input logic [31:0] stamp);
    logic [7:0]  offset;
    logic [15:0] level;
    presses_queued++;
    if ($urandom_range(1) == 1) begin
      queue_word(EV_BUTTON, code, 16'($urandom_range(32767, 1)), stamp);
    end else begin
      offset = code - btn_cnt;
      level  = offset[0] ? 16'($urandom_range(32767, 1)) : {1'b1, 15'($urandom)};
      queue_word(EV_AXIS, {1'($urandom), offset[7:1]}, level, stamp);
    end
  endtask

  task automatic queue_ignored();
    logic [7:0] kind;
    case ($urandom_range(2))
      0: begin
        kind = 8'($urandom);
        if (kind == EV_BUTTON || kind == EV_AXIS) kind[7] = 1'b1;
        queue_word(kind, 8'($urandom), 16'($urandom), $urandom);
      end
      1: queue_word(EV_BUTTON, 8'($urandom),
                    ($urandom_range(1) == 1) ? 16'd0 : {1'b1, 15'($urandom)}, $urandom);
      default: queue_word(EV_AXIS, 8'($urandom), 16'd0, $urandom);
    endcase
  endtask

  // One pass at the command: in the window, at its edge or past it,
  // now and then with a wrong key or an ignored event mixed in
  task automatic queue_command_run();
    int                len;
    longint unsigned   per_step;
    bit                broken;
    bit                exact;
    logic [7:0]        code;
    len = (cmd_len >= 1 && cmd_len <= MaxCmd) ? int'(cmd_len) : $urandom_range(16, 1);
    broken = ($urandom_range(5) == 0);
    exact  = ($urandom_range(3) == 0);
    per_step = (len > 1) ? longint'(win) / (len - 1) : 0;
    if (!exact && $urandom_range(3) == 0) per_step = per_step * 2 + 2;
    if (per_step > 64'hFFFF_FFFF) per_step = 64'hFFFF_FFFF;
    clock_ms += $urandom_range(100000, 1);
    for (int k = 0; k < len; k++) begin
      if (k > 0) begin
        if (exact)
          clock_ms += 32'(per_step) + ((k == len - 1) ? 32'(longint'(win) % (len - 1)) : 32'd0);
        else
          clock_ms += $urandom_range(32'(per_step), 0);
      end
      code = cmd_byte(k);
      if (broken && $urandom_range(len - 1) == 0) code = 8'($urandom);
      if ($urandom_range(7) == 0) queue_ignored();
      queue_press(code, clock_ms);
    end
  endtask

  task automatic run_phase(input int presses);
    int target;
    int pick;
    target = presses_queued + presses;
    while (presses_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        queue_command_run();
      end else if (pick < 75) begin
        repeat ($urandom_range(3, 1)) queue_ignored();
      end else begin
        clock_ms += $urandom_range(5000);
        queue_press(8'($urandom), clock_ms);
      end
    end
  endtask

  // Hold until every word is taken and every result is back, then settle
  task automatic drain_all();
    int waited;
    waited = 0;
    while ((taken_count != queued_count || press_expect.size() != 0) && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    while (press_expect.size() != 0)
      note_failure("expected word never came", press_expect.pop_front(), '0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    logic [31:0] t;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Zero command over a zero history: only the fill count holds back a match
    write_reg(CFG_CODES_LOW, '0);
    write_reg(CFG_CMD_LENGTH, 64'd3);
    write_reg(CFG_TIME_WIN, 64'hFFFF_FFFF);
    end_writes();
    queue_word(EV_BUTTON, 8'd0, 16'd1, 32'd100);
    queue_word(EV_BUTTON, 8'd0, 16'd1, 32'd200);
    queue_word(EV_BUTTON, 8'd0, 16'd1, 32'd300);
    queue_word(8'd0, 8'd1, 16'd1, 32'd400);
    queue_word(8'd3, 8'd2, 16'd7, 32'd500);
    queue_word(8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_word(EV_BUTTON, 8'd4, 16'd0, 32'd600);
    queue_word(EV_BUTTON, 8'd4, 16'hFFFF, 32'd700);
    queue_word(EV_AXIS, 8'd4, 16'd0, 32'd800);
    drain_all();

    write_reg(CFG_CODES_LOW, RST_CODES_LOW);
    write_reg(CFG_CODES_HIGH, RST_CODES_HIGH);
    write_reg(CFG_CMD_LENGTH, 64'(RST_CMD_LENGTH));
    write_reg(CFG_TIME_WIN, 64'(RST_TIME_WIN));
    write_reg(CFG_BTN_COUNT, 64'(RST_BTN_COUNT));
    end_writes();
    // Default command, buttons and axes mixed, span exactly on the window
    // and across the time wrap
    t = 32'hFFFF_F000;
    queue_word(EV_BUTTON, 8'd10, 16'd1, t);
    t += 500; queue_word(EV_AXIS, 8'd1, 16'hFFFF, t);
    t += 500; queue_word(EV_AXIS, 8'd1, 16'h7FFF, t);
    t += 500; queue_word(EV_BUTTON, 8'd11, 16'd5, t);
    t += 500; queue_word(EV_AXIS, 8'd0, 16'h8000, t);
    t += 500; queue_word(EV_BUTTON, 8'd9, 16'd1, t);
    t += 500; queue_word(EV_BUTTON, 8'd8, 16'd1, t);
    t += 500; queue_word(EV_AXIS, 8'd0, 16'd1, t);
    t += 500; queue_word(EV_BUTTON, 8'd2, 16'd1, t);
    t += 1000; queue_word(EV_BUTTON, 8'd3, 16'd1, t);
    t += 1; queue_word(EV_BUTTON, 8'd3, 16'd1, t);
    // Field extremes; large axis numbers wrap the key code
    queue_word(EV_BUTTON, 8'hFF, 16'h7FFF, 32'hFFFF_FFFF);
    queue_word(EV_AXIS, 8'hFF, 16'h8000, 32'd0);
    queue_word(EV_AXIS, 8'h7F, 16'h7FFF, 32'h8000_0000);
    drain_all();

    // Full-length command, no buttons; stop the sender halfway until all is back
    write_reg(CFG_CODES_LOW, {$urandom, $urandom});
    write_reg(CFG_CODES_HIGH, {$urandom, $urandom});
    write_reg(CFG_CMD_LENGTH, 64'(MaxCmd));
    write_reg(CFG_TIME_WIN, 64'($urandom_range(200000, 1000)));
    write_reg(CFG_BTN_COUNT, 64'd0);
    end_writes();
    clock_ms = $urandom;
    run_phase(80);
    drain_all();
    run_phase(80);
    drain_all();

    // Single key command with a zero window
    write_reg(CFG_CODES_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_CMD_LENGTH, 64'd1);
    write_reg(CFG_TIME_WIN, 64'd0);
    write_reg(CFG_BTN_COUNT, 64'd255);
    end_writes();
    run_phase(110);
    drain_all();

    send_idle = 67;
    recv_idle = 31;
    // Widest window with times running through the wrap
    write_reg(CFG_CODES_LOW, {$urandom, $urandom});
    write_reg(CFG_CODES_HIGH, {$urandom, $urandom});
    write_reg(CFG_CMD_LENGTH, 64'($urandom_range(15, 2)));
    write_reg(CFG_TIME_WIN, 64'hFFFF_FFFF);
    write_reg(CFG_BTN_COUNT, 64'($urandom_range(255)));
    end_writes();
    clock_ms = 32'hFFF0_0000;
    run_phase(120);
    drain_all();

    // Zero length never matches
    write_reg(CFG_CODES_HIGH, '0);
    write_reg(CFG_CMD_LENGTH, 64'd0);
    end_writes();
    run_phase(30);
    drain_all();

    send_idle = 0;
    recv_idle = 0;
    // Lengths past the history never match
    write_reg(CFG_CMD_LENGTH, 64'($urandom_range(31, 17)));
    end_writes();
    run_phase(30);
    drain_all();

    write_reg(CFG_CODES_LOW, {$urandom, $urandom});
    write_reg(CFG_CODES_HIGH, {$urandom, $urandom});
    write_reg(CFG_CMD_LENGTH, 64'($urandom_range(16, 1)));
    write_reg(CFG_TIME_WIN, 64'($urandom_range(30000)));
    write_reg(CFG_BTN_COUNT, 64'($urandom_range(255)));
    end_writes();
    clock_ms = $urandom;
    run_phase(170);
    drain_all();

    $display("Run took %0d event words, checked %0d key presses, %0d of them completing",
             taken_count, press_count, hit_count);
    $display("the command, over %0d register settings and three stall patterns.",
             setting_count);
    if (mismatch_count == 0) begin
      $display("PASS timed_key_sequence_detector");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("FAIL timed_key_sequence_detector");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * 2 * HalfPeriod);
    $display("Run did not finish in time");
    $display("FAIL timed_key_sequence_detector");
    $finish;
  end

endmodule
